// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define AOTM_ASSERT_COMB(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aotm assertion failed");

// next-cycle implication, disabled while reset is held
`define AOTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aotm assertion failed");

`endif

// ----- rtl/aotm_pkg.sv -----
`timescale 1ns / 1ps

package aotm_pkg;

  // default id width and fixed field widths
  localparam int ID_BITS_DEF = 7;
  localparam int STAMP_W     = 32;
  localparam int THRESH_W    = 20;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd40000;

  // request operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  // list engine sequencer
  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_WR2,
    S_FIN
  } state_t;

  // engine status towards the top level
  typedef struct packed {
    logic    idle;
    logic    done;
    status_t status;
  } eng_stat_t;

endpackage

// ----- rtl/aotm_in_if.sv -----
`timescale 1ns / 1ps

interface aotm_in_if #(
  parameter int ID_W = aotm_pkg::ID_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic [ID_W-1:0]              txn_id;
  logic [aotm_pkg::STAMP_W-1:0] now_cycle;

  modport source (output valid, output operation, output txn_id, output now_cycle,
                  input ready);
  modport sink (input valid, input operation, input txn_id, input now_cycle,
                output ready);
endinterface

// ----- rtl/aotm_out_if.sv -----
`timescale 1ns / 1ps

interface aotm_out_if #(
  parameter int ID_W = aotm_pkg::ID_BITS_DEF
);
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic            timeout;
  logic [ID_W-1:0] oldest_id;
  logic            any_pending;

  modport source (output valid, output status, output timeout, output oldest_id,
                  output any_pending, input ready);
  modport sink (input valid, input status, input timeout, input oldest_id,
                input any_pending, output ready);
endinterface

// ----- rtl/axi_outstanding_id_timeout_monitor.sv -----
`timescale 1ns / 1ps
// S_RD serves check, error and first insert; insert behind a tail and remove add S_WR2,
// set by the single write port per link memory; S_FIN waits for a free result register
// throughput: one request at a time; the next is taken the cycle after a result
// reset: synchronous active low; a clearing pass sweeps all 2^ID_BITS (128 by default)
// {valid, prev} entries, with in_chan.ready low until it ends; threshold resets to 40000

module axi_outstanding_id_timeout_monitor #(
  parameter int ID_BITS = aotm_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  aotm_in_if.sink                       in_chan,
  aotm_out_if.source                    out_chan,
  input  logic                          cfg_wr_en,
  input  logic [aotm_pkg::THRESH_W-1:0] cfg_wr_data
);
  import aotm_pkg::*;

  logic [THRESH_W-1:0] thresh_r;
  eng_stat_t           stat;
  logic [ID_BITS:0]    head_link;
  logic [STAMP_W-1:0]  head_stamp;
  logic                accept, res_free, pending;
  logic [STAMP_W:0]    deadline;

  logic               res_timeout_r, res_pending_r;
  logic [ID_BITS-1:0] res_oldest_r;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic               out_timeout_r, out_pending_r;
  logic [ID_BITS-1:0] out_oldest_r;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  assign in_chan.ready = stat.idle;
  assign accept        = in_chan.valid && stat.idle;
  assign res_free      = !out_valid_r || out_chan.ready;

  aotm_list #(.ID_BITS(ID_BITS)) u_list (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .op         (in_chan.operation),
    .id         (in_chan.txn_id),
    .now        (in_chan.now_cycle),
    .res_free   (res_free),
    .stat       (stat),
    .head_link  (head_link),
    .head_stamp (head_stamp)
  );

  // head snapshot and timeout judged before the request changes the list
  assign pending  = !head_link[ID_BITS];
  assign deadline = {1'b0, head_stamp} + (STAMP_W + 1)'(thresh_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      res_pending_r <= pending;
      res_oldest_r  <= pending ? head_link[ID_BITS-1:0] : '0;
      res_timeout_r <= pending && (deadline < {1'b0, in_chan.now_cycle});
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_status_r  <= stat.status;
      out_timeout_r <= res_timeout_r;
      out_oldest_r  <= res_oldest_r;
      out_pending_r <= res_pending_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.timeout     = out_timeout_r;
  assign out_chan.oldest_id   = out_oldest_r;
  assign out_chan.any_pending = out_pending_r;

endmodule

// ----- rtl/aotm_list.sv -----
`timescale 1ns / 1ps

module aotm_list #(
  parameter int ID_BITS = aotm_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [1:0]                   op,
  input  logic [ID_BITS-1:0]           id,
  input  logic [aotm_pkg::STAMP_W-1:0] now,
  input  logic                         res_free,
  output aotm_pkg::eng_stat_t          stat,
  output logic [ID_BITS:0]             head_link,
  output logic [aotm_pkg::STAMP_W-1:0] head_stamp
);
  import aotm_pkg::*;

  localparam int DEPTH  = 1 << ID_BITS;
  localparam int LINK_W = ID_BITS + 1;
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(DEPTH);

  // link memories: {valid, prev} and next, plus issue stamps
  logic [LINK_W:0]    pv_mem [DEPTH];
  logic [LINK_W-1:0]  nx_mem [DEPTH];
  logic [STAMP_W-1:0] st_mem [DEPTH];

  logic [LINK_W:0]    pv_rd_r;
  logic [LINK_W-1:0]  nx_rd_r;
  logic [STAMP_W-1:0] st_rd_r;

  logic               pv_we, nx_we, st_we;
  logic [ID_BITS-1:0] pv_waddr, nx_waddr, st_waddr, st_raddr;
  logic [LINK_W:0]    pv_wdata;
  logic [LINK_W-1:0]  nx_wdata;
  logic [STAMP_W-1:0] st_wdata;

  state_t             state_r, state_nxt;
  logic [ID_BITS-1:0] clr_r;
  logic [1:0]         op_r;
  logic [ID_BITS-1:0] id_r;
  logic [STAMP_W-1:0] now_r;
  logic [LINK_W-1:0]  head_r, tail_r, aux_r;
  logic [STAMP_W-1:0] head_stamp_r;
  logic               hs_load_r;
  status_t            status_r;

  // decode of the entry read for the current request
  logic              rd_valid;
  logic [LINK_W-1:0] rd_prev, rd_next;
  logic              is_ins, is_rem, ins_ok, rem_ok, need2;
  status_t           rd_status;

  assign rd_valid = pv_rd_r[LINK_W];
  assign rd_prev  = pv_rd_r[LINK_W-1:0];
  assign rd_next  = nx_rd_r;
  assign st_raddr = nx_rd_r[ID_BITS-1:0];

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    case (op_r)
      OP_INSERT: is_ins = 1'b1;
      OP_REMOVE: is_rem = 1'b1;
      default:   ;
    endcase
    ins_ok = is_ins && !rd_valid;
    rem_ok = is_rem && rd_valid;
    need2  = (ins_ok && !tail_r[ID_BITS]) || rem_ok;
    if (is_ins && rd_valid) begin
      rd_status = ST_DUP;
    end else if (is_rem && !rd_valid) begin
      rd_status = ST_MISSING;
    end else begin
      rd_status = ST_OK;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (&clr_r) state_nxt = S_IDLE;
      S_IDLE: if (start) state_nxt = S_RD;
      S_RD: begin
        if (need2) begin
          state_nxt = S_WR2;
        end else begin
          state_nxt = res_free ? S_IDLE : S_FIN;
        end
      end
      S_WR2:  state_nxt = res_free ? S_IDLE : S_FIN;
      S_FIN:  if (res_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  // outputs and memory write ports
  always_comb begin
    stat.idle   = 1'b0;
    stat.done   = 1'b0;
    stat.status = status_r;
    pv_we    = 1'b0;
    pv_waddr = id_r;
    pv_wdata = {1'b0, LINK_NULL};
    nx_we    = 1'b0;
    nx_waddr = id_r;
    nx_wdata = LINK_NULL;
    st_we    = 1'b0;
    st_waddr = id_r;
    st_wdata = now_r;
    unique case (state_r)
      S_CLR: begin
        pv_we    = 1'b1;
        pv_waddr = clr_r;
      end
      S_IDLE: stat.idle = 1'b1;
      S_RD: begin
        stat.status = rd_status;
        stat.done   = !need2 && res_free;
        if (ins_ok) begin
          pv_we    = 1'b1;
          pv_wdata = {1'b1, tail_r};
          nx_we    = 1'b1;
          st_we    = 1'b1;
        end
        if (rem_ok) begin
          // neighbours skip over the removed entry
          pv_we    = !rd_next[ID_BITS];
          pv_waddr = rd_next[ID_BITS-1:0];
          pv_wdata = {1'b1, rd_prev};
          nx_we    = !rd_prev[ID_BITS];
          nx_waddr = rd_prev[ID_BITS-1:0];
          nx_wdata = rd_next;
        end
      end
      S_WR2: begin
        stat.done = res_free;
        if (is_ins) begin
          // old tail points at the new entry
          nx_we    = 1'b1;
          nx_waddr = aux_r[ID_BITS-1:0];
          nx_wdata = {1'b0, id_r};
        end else begin
          pv_we = 1'b1;
        end
      end
      S_FIN: stat.done = res_free;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
    if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (start) begin
      pv_rd_r <= pv_mem[id];
      nx_rd_r <= nx_mem[id];
    end
    st_rd_r <= st_mem[st_raddr];
  end

  // sequencer state, clear counter and list pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      head_r    <= LINK_NULL;
      tail_r    <= LINK_NULL;
      hs_load_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (state_r == S_RD) begin
        hs_load_r <= rem_ok && rd_prev[ID_BITS] && !rd_next[ID_BITS];
        if (ins_ok) begin
          tail_r <= {1'b0, id_r};
          if (head_r[ID_BITS]) head_r <= {1'b0, id_r};
        end
        if (rem_ok) begin
          if (rd_prev[ID_BITS]) head_r <= rd_next;
          if (rd_next[ID_BITS]) tail_r <= rd_prev;
        end
      end
      if (state_r == S_WR2) hs_load_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= op;
      id_r  <= id;
      now_r <= now;
    end
    if (state_r == S_RD) begin
      status_r <= rd_status;
      aux_r    <= tail_r;
      if (ins_ok && head_r[ID_BITS]) head_stamp_r <= now_r;
    end
    if (state_r == S_WR2 && hs_load_r) head_stamp_r <= st_rd_r;
  end

  assign head_link  = head_r;
  assign head_stamp = head_stamp_r;

endmodule

// ----- rtl/aotm_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aotm_checker #(
  parameter int ID_BITS = aotm_pkg::ID_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic               out_timeout,
  input logic [ID_BITS-1:0] out_oldest_id,
  input logic               out_any_pending
);
  import aotm_pkg::*;

  // a waiting result stays until taken
  `AOTM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // one request at a time: ready drops right after an accept
  `AOTM_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

  // an empty list never times out and reports id zero
  `AOTM_ASSERT_COMB(a_empty_quiet, clk, rst_n, out_valid && !out_any_pending, !out_timeout && out_oldest_id == '0)

  // only defined status codes leave the block
  `AOTM_ASSERT_COMB(a_status_code, clk, rst_n, out_valid, out_status == ST_OK || out_status == ST_DUP || out_status == ST_MISSING)

endmodule

bind axi_outstanding_id_timeout_monitor aotm_checker #(.ID_BITS(ID_BITS)) u_aotm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_timeout     (out_chan.timeout),
  .out_oldest_id   (out_chan.oldest_id),
  .out_any_pending (out_chan.any_pending)
);
